// ===== rtl/ptmap_pkg.sv =====
// Shared constants and types for the four-level page-table mapper.
// Field widths, entry layout, command and status codes.
// No dependencies.
package ptmap_pkg;

  // Default size of the table frame pool
  localparam int TABLE_FRAMES_DEF = 16;

  // Table geometry
  localparam int IDX_W   = 9;
  localparam int ENTRY_W = 64;
  localparam int OFFS_W  = 12;

  // Field widths
  localparam int BASE_W   = 40;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int FLAGS_W  = 12;
  localparam int STATUS_W = 2;
  localparam int FIU_W    = 5;

  // Stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;

  // Flags written into a newly created intermediate entry
  localparam logic [OFFS_W-1:0] TABLE_ENTRY_FLAGS = 12'h007;

  // Command codes
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_MISSING  = 2'd2
  } status_t;

endpackage

// ===== rtl/four_level_page_table_mapper.sv =====
// Four-level page-table mapper over a pool of TABLE_FRAMES table frames.
// A full walk makes three dependent reads, then the leaf write and the
// result; a walk that stops early skips the rest. A new command is taken
// only once the result of the last one is in the result register.
// Reset: synchronous; a clearing pass over all TABLE_FRAMES*512 entries
// (8192 by default) zeroes the table store, with in_tready low until it ends.
module four_level_page_table_mapper #(
  parameter int TABLE_FRAMES = ptmap_pkg::TABLE_FRAMES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: pool_frame_base
  input  logic                                 cfg_we,
  input  logic [ptmap_pkg::BASE_W-1:0]         cfg_wdata,
  // command stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ptmap_pkg::IN_TDATA_W-1:0]     in_tdata,  // va, pa, flags
  input  logic                                 in_tuser,  // command
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ptmap_pkg::OUT_TDATA_W-1:0]    out_tdata  // status, frames_in_use, zero pad
);

  localparam int DEPTH = TABLE_FRAMES * 512;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0]                        mem_addr;
  logic                                 mem_we;
  logic [ptmap_pkg::ENTRY_W-1:0]        mem_wdata;
  logic [ptmap_pkg::ENTRY_W-1:0]        mem_rdata;
  logic [ptmap_pkg::STATUS_W-1:0]       status;
  logic [ptmap_pkg::FIU_W-1:0]          fiu;

  // Walk sequencer
  ptmap_walker #(
    .TABLE_FRAMES (TABLE_FRAMES),
    .AW           (AW)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_va      (in_tdata[47:0]),
    .in_pa      (in_tdata[99:48]),
    .in_flags   (in_tdata[111:100]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_fiu    (fiu),
    .mem_addr   (mem_addr),
    .mem_we     (mem_we),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // Table store
  ptmap_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ptmap_pkg::ENTRY_W)
  ) u_table_ram (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_tdata = {1'b0, fiu, status};

endmodule

// ===== rtl/ptmap_table_ram.sv =====
// Single-port table memory with registered read.
// Read-first on a write to the same address. Depends on nothing.
module ptmap_table_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write and registered read on the one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptmap_walker.sv =====
// Walk sequencer for the page-table mapper: clearing pass, four-level walk,
// frame allocation, leaf update and result register. Uses ptmap_pkg and
// drives the single port of ptmap_table_ram.
module ptmap_walker #(
  parameter int TABLE_FRAMES = ptmap_pkg::TABLE_FRAMES_DEF,
  parameter int AW           = $clog2(TABLE_FRAMES * 512)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ptmap_pkg::BASE_W-1:0]      cfg_wdata,
  // command side
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [ptmap_pkg::VA_W-1:0]        in_va,
  input  logic [ptmap_pkg::PA_W-1:0]        in_pa,
  input  logic [ptmap_pkg::FLAGS_W-1:0]     in_flags,
  // result side
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptmap_pkg::STATUS_W-1:0]    out_status,
  output logic [ptmap_pkg::FIU_W-1:0]       out_fiu,
  // table memory port
  output logic [AW-1:0]                     mem_addr,
  output logic                              mem_we,
  output logic [ptmap_pkg::ENTRY_W-1:0]     mem_wdata,
  input  logic [ptmap_pkg::ENTRY_W-1:0]     mem_rdata
);

  localparam int DEPTH = TABLE_FRAMES * 512;
  localparam int FW    = AW - ptmap_pkg::IDX_W;
  localparam int CW    = $clog2(TABLE_FRAMES + 1);
  localparam int BW    = ptmap_pkg::BASE_W;
  localparam int OW    = ptmap_pkg::OFFS_W;
  localparam int PFN_W = ptmap_pkg::ENTRY_W - OW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LEAF,
    S_RESP
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [1:0]                      level_r, level_nxt;
  logic [FW-1:0]                   frame_r, frame_nxt;
  logic [CW-1:0]                   used_r, used_nxt;
  logic [BW-1:0]                   base_r, base_nxt;
  logic                            cmd_r, cmd_nxt;
  logic [ptmap_pkg::VA_W-1:0]      va_r, va_nxt;
  logic [ptmap_pkg::PA_W-1:0]      pa_r, pa_nxt;
  logic [ptmap_pkg::FLAGS_W-1:0]   flags_r, flags_nxt;
  ptmap_pkg::status_t              status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ptmap_pkg::status_t              out_status_r, out_status_nxt;
  logic [ptmap_pkg::FIU_W-1:0]     out_fiu_r, out_fiu_nxt;

  logic [ptmap_pkg::IDX_W-1:0]     idx;
  logic [AW-1:0]                   slot;
  logic [PFN_W:0]                  diff;
  logic                            hit;
  logic                            pool_full;
  logic [BW-1:0]                   alloc_pfn;
  logic [ptmap_pkg::ENTRY_W-1:0]   alloc_entry;
  logic [ptmap_pkg::ENTRY_W-1:0]   leaf_entry;
  logic [CW+ptmap_pkg::FIU_W-1:0]  used_ext;

  // Pick the table index for the current level
  always_comb begin
    case (level_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign slot = {frame_r, idx};

  // Follow the entry just read: present and naming an allocated frame
  assign diff = {1'b0, mem_rdata[ptmap_pkg::ENTRY_W-1:OW]} - {{(PFN_W+1-BW){1'b0}}, base_r};
  assign hit  = mem_rdata[0] && !diff[PFN_W]
             && (diff[PFN_W-1:0] < {{(PFN_W-CW){1'b0}}, used_r});

  assign pool_full   = (used_r >= CW'(TABLE_FRAMES));
  assign alloc_pfn   = base_r + {{(BW-CW){1'b0}}, used_r};
  assign alloc_entry = {{(PFN_W-BW){1'b0}}, alloc_pfn, ptmap_pkg::TABLE_ENTRY_FLAGS};
  assign leaf_entry  = (cmd_r == ptmap_pkg::CMD_UNMAP) ? '0 :
                       {{(ptmap_pkg::ENTRY_W-ptmap_pkg::PA_W){1'b0}},
                        pa_r[ptmap_pkg::PA_W-1:OW], flags_r | OW'(1)};
  assign used_ext    = {{ptmap_pkg::FIU_W{1'b0}}, used_r};

  // Memory port: clearing sweep, walk reads, allocation and leaf writes
  always_comb begin
    mem_addr  = slot;
    mem_we    = 1'b0;
    mem_wdata = leaf_entry;
    case (state_r)
      S_CLEAR: begin
        mem_addr  = clr_r;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_EVAL: begin
        mem_we    = !hit && (cmd_r == ptmap_pkg::CMD_MAP) && !pool_full;
        mem_wdata = alloc_entry;
      end
      S_LEAF: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next-state and register updates
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    level_nxt      = level_r;
    frame_nxt      = frame_r;
    used_nxt       = used_r;
    base_nxt       = cfg_we ? cfg_wdata : base_r;
    cmd_nxt        = cmd_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    flags_nxt      = flags_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_fiu_nxt    = out_fiu_r;

    case (state_r)
      // Sweep the table store to zero after reset
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      // Take a command and start at the root
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          va_nxt    = in_va;
          pa_nxt    = in_pa;
          flags_nxt = in_flags;
          level_nxt = 2'd0;
          frame_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      // Descend, allocate a missing level, or stop
      S_EVAL: begin
        if (hit || ((cmd_r == ptmap_pkg::CMD_MAP) && !pool_full)) begin
          if (hit) begin
            frame_nxt = diff[FW-1:0];
          end else begin
            frame_nxt = used_r[FW-1:0];
            used_nxt  = used_r + CW'(1);
          end
          level_nxt = level_r + 2'd1;
          state_nxt = (level_r == 2'd2) ? S_LEAF : S_READ;
        end else begin
          status_nxt = (cmd_r == ptmap_pkg::CMD_UNMAP) ? ptmap_pkg::ST_MISSING
                                                       : ptmap_pkg::ST_NO_FRAME;
          state_nxt  = S_RESP;
        end
      end
      S_LEAF: begin
        status_nxt = ptmap_pkg::ST_DONE;
        state_nxt  = S_RESP;
      end
      // Load the result register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_fiu_nxt    = used_ext[ptmap_pkg::FIU_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      level_r     <= '0;
      frame_r     <= '0;
      used_r      <= CW'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      level_r     <= level_nxt;
      frame_r     <= frame_nxt;
      used_r      <= used_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    flags_r      <= flags_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_fiu_r    <= out_fiu_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_fiu    = out_fiu_r;

endmodule

// ===== tb/ptmap_checker.sv =====
// Checker for the four-level page-table mapper: watches the config, command
// and result channels, predicts each result and compares it.
// Depends on ptmap_pkg for field widths, command and status codes.
`timescale 1ns / 1ps

module ptmap_checker
  import ptmap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [BASE_W-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // va, pa, flags
  input  logic                   in_tuser,   // command
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // status, frames_in_use, zero pad
  output int                     fail_count,
  output int                     outstanding
);

  localparam int POOL_FRAMES = TABLE_FRAMES_DEF;
  localparam int SLOTS       = POOL_FRAMES * 512;

  typedef struct packed {
    status_t          st;
    logic [FIU_W-1:0] fiu;
  } walk_result_t;

  // Shadow of the table memory, allocation count and pool base
  logic [ENTRY_W-1:0] shadow_tbl [SLOTS];
  int unsigned        frames_used;
  logic [BASE_W-1:0]  pool_base;

  walk_result_t pending_results [$];
  walk_result_t want;
  status_t      got_st;
  logic [VA_W-1:0]    cmd_va;
  logic [PA_W-1:0]    cmd_pa;
  logic [FLAGS_W-1:0] cmd_fl;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Resolve one entry to an allocated frame, relative to the current base
  function automatic bit follow_entry(input logic [ENTRY_W-1:0] ent,
                                      output int unsigned nxt);
    logic [63:0] rel;
    nxt = 0;
    if (!ent[0]) return 1'b0;
    rel = {12'b0, ent[63:12]} - {24'b0, pool_base};
    if (rel >= 64'(frames_used)) return 1'b0;
    nxt = rel[31:0];
    return 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, int lvl);
    return IDX_W'(va >> (39 - 9 * lvl));
  endfunction

  // Walk and build missing levels, then write the leaf
  function automatic status_t predict_map(logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                          logic [FLAGS_W-1:0] fl);
    int unsigned frame;
    int unsigned nxt;
    int unsigned slot;
    logic [63:0] fr;
    frame = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      slot = frame * 512 + level_index(va, lvl);
      if (!follow_entry(shadow_tbl[slot], nxt)) begin
        if (frames_used >= POOL_FRAMES) return ST_NO_FRAME;
        nxt = frames_used;
        frames_used++;
        fr = {24'b0, pool_base} + 64'(nxt);
        shadow_tbl[slot] = {12'b0, fr[39:0], TABLE_ENTRY_FLAGS};
      end
      frame = nxt;
    end
    shadow_tbl[frame * 512 + va[20:12]] = {12'b0, pa[51:12], fl[11:1], 1'b1};
    return ST_DONE;
  endfunction

  // Walk without building; stop at the first missing level
  function automatic status_t predict_unmap(logic [VA_W-1:0] va);
    int unsigned frame;
    int unsigned nxt;
    frame = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (!follow_entry(shadow_tbl[frame * 512 + level_index(va, lvl)], nxt))
        return ST_MISSING;
      frame = nxt;
    end
    shadow_tbl[frame * 512 + va[20:12]] = '0;
    return ST_DONE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) shadow_tbl[i] = '0;
      frames_used = 1;
      pool_base   = '0;
      pending_results.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (cfg_we) pool_base = cfg_wdata;

      // Compare a result transaction with the oldest prediction
      if (out_tvalid && out_tready) begin
        got_st = status_t'(out_tdata[1:0]);
        if (pending_results.size() == 0) begin
          report($sformatf("result status %0d fiu %0d with nothing pending",
                           out_tdata[1:0], out_tdata[6:2]));
        end else begin
          want = pending_results.pop_front();
          if (got_st != want.st)
            report($sformatf("status got %0d expected %0d", got_st, want.st));
          if (out_tdata[6:2] != want.fiu)
            report($sformatf("frames_in_use got %0d expected %0d",
                             out_tdata[6:2], want.fiu));
        end
      end

      // Predict the result of a command transaction
      if (in_tvalid && in_tready) begin
        cmd_va = in_tdata[47:0];
        cmd_pa = in_tdata[99:48];
        cmd_fl = in_tdata[111:100];
        if (in_tuser == CMD_MAP) want.st = predict_map(cmd_va, cmd_pa, cmd_fl);
        else want.st = predict_unmap(cmd_va);
        want.fiu = frames_used[FIU_W-1:0];
        pending_results.push_back(want);
      end

      outstanding = pending_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the page-table mapper testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ptmap_pkg, the mapper RTL and ptmap_checker.
`timescale 1ns / 1ps

module tb;
  import ptmap_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 285;

  // Receiver back-pressure modes
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [BASE_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     outstanding;

  int                burst_left = 0;
  int                quiet_cycles = 0;
  logic [VA_W-1:0]   va_pool [$];
  logic [BASE_W-1:0] phase_base [PHASES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  four_level_page_table_mapper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ptmap_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] make_va(logic [8:0] l4, logic [8:0] l3,
                                              logic [8:0] l2, logic [8:0] l1);
    return {l4, l3, l2, l1, 12'h000};
  endfunction

  // Present one command, in bursts with random gaps between them
  task automatic send_command(logic cmd, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                              logic [FLAGS_W-1:0] fl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {fl, pa, va};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain, let the block settle, then write the pool base
  task automatic write_base(logic [BASE_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Field extremes, early stops, absent leaf and pool exhaustion
  task automatic directed_commands();
    logic [VA_W-1:0] all_ones;
    all_ones = '1;
    send_command(CMD_MAP, '0, '0, '0);
    send_command(CMD_MAP, all_ones, '1, '1);
    send_command(CMD_MAP, '0, PA_W'(rand64()), 12'hFFE);
    send_command(CMD_UNMAP, all_ones, '0, '0);
    // leaf already clear
    send_command(CMD_UNMAP, all_ones, '0, '0);
    // missing at each of the upper three levels
    send_command(CMD_UNMAP, make_va(9'd5, 9'd0, 9'd0, 9'd0), '0, '0);
    send_command(CMD_UNMAP, make_va(9'd0, 9'd1, 9'd0, 9'd0), '0, '0);
    send_command(CMD_UNMAP, make_va(9'd0, 9'd0, 9'd1, 9'd0), '0, '0);
    send_command(CMD_MAP, make_va(9'd1, 9'd2, 9'd3, 9'd4), '1, 12'h000);
    send_command(CMD_MAP, make_va(9'd2, 9'd511, 9'd0, 9'd511), PA_W'(rand64()), 12'hFFF);
    send_command(CMD_MAP, make_va(9'd0, 9'd1, 9'd0, 9'd7), PA_W'(rand64()), 12'h0A5);
    // pool runs out part way down; the level already built stays
    send_command(CMD_MAP, make_va(9'd3, 9'd0, 9'd0, 9'd0), PA_W'(rand64()), 12'h123);
    send_command(CMD_MAP, make_va(9'd3, 9'd0, 9'd0, 9'd0), PA_W'(rand64()), 12'h456);
    send_command(CMD_UNMAP, make_va(9'd3, 9'd0, 9'd0, 9'd0), '0, '0);
    send_command(CMD_MAP, make_va(9'd0, 9'd0, 9'd0, 9'd9) | 48'hFFF, '1, '1);
    send_command(CMD_UNMAP, make_va(9'd0, 9'd0, 9'd0, 9'd9), '1, '1);
    va_pool.push_back('0);
    va_pool.push_back(all_ones);
    va_pool.push_back(make_va(9'd1, 9'd2, 9'd3, 9'd4));
    va_pool.push_back(make_va(9'd2, 9'd511, 9'd0, 9'd511));
    va_pool.push_back(make_va(9'd0, 9'd1, 9'd0, 9'd7));
    va_pool.push_back(make_va(9'd3, 9'd0, 9'd0, 9'd0));
  endtask

  // Mostly walks along known paths, some fully random addresses
  task automatic random_command();
    logic [VA_W-1:0] va;
    logic            cmd;
    if ($urandom_range(0, 99) < 80 && va_pool.size() > 0) begin
      va = va_pool[$urandom_range(0, va_pool.size() - 1)];
      if ($urandom_range(0, 1)) va[20:12] = 9'($urandom);
      if ($urandom_range(0, 9) == 0) va[29:21] = 9'($urandom);
      va[11:0] = 12'($urandom);
    end else begin
      va = VA_W'(rand64());
    end
    cmd = ($urandom_range(0, 9) < 6) ? CMD_MAP : CMD_UNMAP;
    if (cmd == CMD_MAP) begin
      if (va_pool.size() < 64) va_pool.push_back(va);
      else va_pool[$urandom_range(0, 63)] = va;
    end
    send_command(cmd, va, PA_W'(rand64()), FLAGS_W'($urandom));
  endtask

  // Result back-pressure: runs of open, random and sparse acceptance
  initial begin : receiver
    int mode;
    int run_left;
    mode       = RX_OPEN;
    run_left   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        mode     = $urandom_range(RX_OPEN, RX_SPARSE);
        run_left = $urandom_range(16, 160);
      end
      run_left--;
      case (mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_MAP;
    phase_base[0] = '0;
    phase_base[1] = 40'd1;
    phase_base[2] = '1;
    phase_base[3] = 40'd3;
    phase_base[4] = BASE_W'(rand64());
    phase_base[5] = 40'd15;
    phase_base[6] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      write_base(phase_base[p]);
      if (p == 0) directed_commands();
      repeat (PHASE_ITEMS) random_command();
    end

    // Drain and settle before the verdict
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptmap_pkg.sv
rtl/ptmap_table_ram.sv
rtl/ptmap_walker.sv
rtl/four_level_page_table_mapper.sv
tb/ptmap_checker.sv
tb/tb.sv
